[rtl/core/bvp_pkg.sv]
// bvp_pkg: shared types and constants for the battery voltage to percent block.
// Holds the fixed 16-point charge curve, field widths and code names.
// No dependencies.
`timescale 1ns / 1ps
package bvp_pkg;

	localparam int MV_W        = 13;
	localparam int PCT_W       = 7;
	localparam int CURVE_POINTS = 16;
	localparam int SEG_W       = $clog2(CURVE_POINTS);
	localparam int DELTA_W     = 4;
	localparam int DIST_W      = 7;
	localparam int PROD_W      = DELTA_W + DIST_W;
	localparam int NUM_W       = 11;
	localparam int FRAC_W      = 4;

	// reciprocal of 100: floor(x / 100) == (x * 5243) >> 19 for x < 43000
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

	localparam logic [MV_W-1:0] SPAN_NARROW = 13'd50;

	typedef logic [MV_W-1:0]  mv_t;
	typedef logic [PCT_W-1:0] pct_t;

	localparam mv_t CURVE_MV [CURVE_POINTS] = '{
		13'd3400, 13'd3450, 13'd3500, 13'd3550,
		13'd3600, 13'd3650, 13'd3700, 13'd3750,
		13'd3800, 13'd3850, 13'd3900, 13'd4000,
		13'd4050, 13'd4100, 13'd4150, 13'd4200
	};

	localparam pct_t CURVE_PCT [CURVE_POINTS] = '{
		7'd0,  7'd2,  7'd5,  7'd9,
		7'd14, 7'd20, 7'd28, 7'd37,
		7'd48, 7'd58, 7'd68, 7'd82,
		7'd88, 7'd93, 7'd97, 7'd100
	};

	typedef enum logic [1:0] {
		CHG_IDLE = 2'd0,
		CHG_PRE  = 2'd1,
		CHG_FAST = 2'd2,
		CHG_DONE = 2'd3
	} chg_status_t;

	localparam logic REG_PRESENT_MIN = 1'b0;
	localparam logic REG_PRESENT_MAX = 1'b1;

	typedef struct packed {
		logic              present;
		pct_t              base_pct;
		logic [NUM_W-1:0]  num;
	} seg_t;

endpackage

[rtl/core/bvp_seg.sv]
// bvp_seg: presence window check, curve segment select and scaled offset.
// Produces base percent and the rounding numerator over 100.
// Depends on bvp_pkg.
`timescale 1ns / 1ps
module bvp_seg import bvp_pkg::*; (
	input  mv_t  mv,
	input  mv_t  min_mv,
	input  mv_t  max_mv,
	output seg_t seg
);

	logic [SEG_W-1:0]   sel;
	mv_t                v0;
	mv_t                span;
	logic [DELTA_W-1:0] delta;
	logic [DIST_W-1:0]  offs;
	logic [PROD_W-1:0]  prod;
	logic               present;

	always_comb begin
		sel = SEG_W'(CURVE_POINTS - 1);
		for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
			if (mv <= CURVE_MV[i]) begin
				sel = SEG_W'(i);
			end
		end
	end

	always_comb begin
		v0    = CURVE_MV[sel - SEG_W'(1)];
		span  = CURVE_MV[sel] - v0;
		delta = DELTA_W'(CURVE_PCT[sel] - CURVE_PCT[sel - SEG_W'(1)]);
		offs  = DIST_W'(mv - v0);
		prod  = PROD_W'(delta) * PROD_W'(offs);
	end

	assign present = (mv >= min_mv) && (mv <= max_mv);

	always_comb begin
		seg.present  = present;
		seg.base_pct = '0;
		seg.num      = '0;
		if (present) begin
			if (mv <= CURVE_MV[0]) begin
				seg.base_pct = CURVE_PCT[0];
			end else if (mv >= CURVE_MV[CURVE_POINTS-1]) begin
				seg.base_pct = CURVE_PCT[CURVE_POINTS-1];
			end else begin
				seg.base_pct = CURVE_PCT[sel - SEG_W'(1)];
				// narrow span: (2*d*x + 50) / 100; wide span: (d*x + 50) / 100
				if (span == SPAN_NARROW) begin
					seg.num = NUM_W'({prod, 1'b0}) + NUM_W'(50);
				end else begin
					seg.num = NUM_W'(prod) + NUM_W'(50);
				end
			end
		end
	end

endmodule

[rtl/core/bvp_scale.sv]
// bvp_scale: divides the rounding numerator by 100 and adds the base percent.
// Division by reciprocal multiplication.
// Depends on bvp_pkg.
`timescale 1ns / 1ps
module bvp_scale import bvp_pkg::*; (
	input  seg_t seg,
	output pct_t pct
);

	logic [NUM_W+RECIP_W-1:0] prod;
	logic [FRAC_W-1:0]        frac;

	assign prod = (NUM_W + RECIP_W)'(seg.num) * (NUM_W + RECIP_W)'(RECIP_100);
	assign frac = prod[RECIP_SHIFT +: FRAC_W];
	assign pct  = seg.base_pct + PCT_W'(frac);

endmodule

[rtl/core/battery_voltage_to_percent.sv]
// battery_voltage_to_percent: battery voltage to state of charge, with flags.
// Three register stages: input, segment/product, result.
// A transfer moves through the input, segment/product and result registers in that order.
// Throughput: one transfer per cycle; each stage advances when the next is free.
// Reset: pipeline empty, presence window 2500..4600 mV.
`timescale 1ns / 1ps
module battery_voltage_to_percent import bvp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  mv_t        cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  mv_t        battery_mv,
	input  logic [1:0] charge_status,
	input  logic [2:0] ntc_status,
	output logic       out_valid,
	input  logic       out_stall,
	output pct_t       percent,
	output logic       present,
	output logic       charging,
	output logic       ntc_fault
);

	mv_t        min_mv_q, max_mv_q;

	logic       vld_s1, vld_s2;
	mv_t        mv_s1;
	logic       chg_s1, ntc_s1;
	seg_t       seg_s2;
	logic       chg_s2, ntc_s2;

	logic       en_s1, en_s2, en_out;
	logic       chg_dec;
	seg_t       seg;
	pct_t       pct;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mv_q <= 13'd2500;
			max_mv_q <= 13'd4600;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PRESENT_MIN: min_mv_q <= cfg_data;
				REG_PRESENT_MAX: max_mv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en_out   = !out_valid || !out_stall;
	assign en_s2    = !vld_s2 || en_out;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_stall = !en_s1;

	always_comb begin
		case (charge_status) inside
			CHG_PRE, CHG_FAST: chg_dec = 1'b1;
			default:           chg_dec = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_s1)  vld_s1    <= in_valid;
			if (en_s2)  vld_s2    <= vld_s1;
			if (en_out) out_valid <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			mv_s1  <= battery_mv;
			chg_s1 <= chg_dec;
			ntc_s1 <= (ntc_status != 3'd0);
		end
		if (en_s2 && vld_s1) begin
			seg_s2 <= seg;
			chg_s2 <= chg_s1;
			ntc_s2 <= ntc_s1;
		end
		if (en_out && vld_s2) begin
			percent   <= pct;
			present   <= seg_s2.present;
			charging  <= chg_s2;
			ntc_fault <= ntc_s2;
		end
	end

	bvp_seg u_seg (
		.mv     (mv_s1),
		.min_mv (min_mv_q),
		.max_mv (max_mv_q),
		.seg    (seg)
	);

	bvp_scale u_scale (
		.seg (seg_s2),
		.pct (pct)
	);

endmodule

[test/bvp_checker.sv]
// bvp_checker: watches the config port and both channels of battery_voltage_to_percent.
// Predicts each result from its own charge curve and presence window and checks it field by field.
// Depends on bvp_pkg for port types, charger codes and register indexes.
`timescale 1ns / 1ps
module bvp_checker import bvp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  mv_t        cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  mv_t        battery_mv,
	input  logic [1:0] charge_status,
	input  logic [2:0] ntc_status,
	input  logic       out_valid,
	input  logic       out_stall,
	input  pct_t       percent,
	input  logic       present,
	input  logic       charging,
	input  logic       ntc_fault,
	output int         errors,
	output int         pending,
	output int         results
);

	localparam int SOC_MV [16] = '{
		3400, 3450, 3500, 3550, 3600, 3650, 3700, 3750,
		3800, 3850, 3900, 4000, 4050, 4100, 4150, 4200
	};
	localparam int SOC_PCT [16] = '{
		0, 2, 5, 9, 14, 20, 28, 37, 48, 58, 68, 82, 88, 93, 97, 100
	};

	typedef struct packed {
		pct_t pct;
		logic present;
		logic charging;
		logic ntc_fault;
	} soc_result_t;

	mv_t         win_min;
	mv_t         win_max;
	soc_result_t soc_q [$];
	soc_result_t want;

	initial errors = 0;

	function automatic soc_result_t predict_soc(mv_t v, logic [1:0] cs, logic [2:0] ntc);
		soc_result_t r;
		int          mv;
		int          span;
		int          acc;
		int          pct_i;
		bit          found;
		mv = int'(v);
		pct_i = 0;
		found = 1'b0;
		r.present = (v >= win_min) && (v <= win_max);
		if (mv <= SOC_MV[0]) begin
			pct_i = SOC_PCT[0];
		end else if (mv >= SOC_MV[15]) begin
			pct_i = SOC_PCT[15];
		end else begin
			for (int i = 1; i < 16; i++) begin
				if (!found && mv <= SOC_MV[i]) begin
					found = 1'b1;
					span = SOC_MV[i] - SOC_MV[i-1];
					// round half up: (2*span*p0 + 2*dp*dv + span) / (2*span)
					acc = 2 * span * SOC_PCT[i-1]
						+ 2 * (SOC_PCT[i] - SOC_PCT[i-1]) * (mv - SOC_MV[i-1]) + span;
					pct_i = acc / (2 * span);
				end
			end
			if (pct_i > 100)
				pct_i = 100;
		end
		r.pct = r.present ? pct_t'(pct_i) : '0;
		r.charging = (cs == CHG_PRE) || (cs == CHG_FAST);
		r.ntc_fault = |ntc;
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int exp_val);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, exp_val);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_min <= 13'd2500;
			win_max <= 13'd4600;
			soc_q.delete();
			pending <= 0;
			results <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PRESENT_MIN: win_min <= cfg_data;
					REG_PRESENT_MAX: win_max <= cfg_data;
				endcase
			end
			if (in_valid && !in_stall)
				soc_q.push_back(predict_soc(battery_mv, charge_status, ntc_status));
			if (out_valid && !out_stall) begin
				results <= results + 1;
				if (soc_q.size() == 0) begin
					$display("%0t: result transfer with no expected result", $realtime);
					errors++;
				end else begin
					want = soc_q.pop_front();
					if (percent !== want.pct)
						report_mismatch("percent", percent, want.pct);
					if (present !== want.present)
						report_mismatch("present", present, want.present);
					if (charging !== want.charging)
						report_mismatch("charging", charging, want.charging);
					if (ntc_fault !== want.ntc_fault)
						report_mismatch("ntc_fault", ntc_fault, want.ntc_fault);
				end
			end
			pending <= soc_q.size();
		end
	end

endmodule

[test/battery_voltage_to_percent_tb.sv]
// battery_voltage_to_percent_tb: stimulus and verdict for battery_voltage_to_percent.
// Directed edge cases, then random voltages across several presence windows and flow-control profiles.
// Depends on bvp_pkg, the block and bvp_checker.
`timescale 1ns / 1ps
module battery_voltage_to_percent_tb;
	import bvp_pkg::*;

	localparam int LIMIT     = 300000;
	localparam int NUM_WIN   = 8;
	localparam int PHASE_LEN = 210;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic       cfg_index;
	mv_t        cfg_data;
	logic       in_valid;
	logic       in_stall;
	mv_t        battery_mv;
	logic [1:0] charge_status;
	logic [2:0] ntc_status;
	logic       out_valid;
	logic       out_stall;
	pct_t       percent;
	logic       present;
	logic       charging;
	logic       ntc_fault;

	int errors;
	int pending;
	int results;
	int sent = 0;
	int cycle_cnt = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int cur_lo = 2500;
	int cur_hi = 4600;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= REG_PRESENT_MIN;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		battery_mv    <= '0;
		charge_status <= CHG_IDLE;
		ntc_status    <= '0;
		out_stall     <= 1'b0;
	end

	battery_voltage_to_percent i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.battery_mv(battery_mv), .charge_status(charge_status), .ntc_status(ntc_status),
		.out_valid(out_valid), .out_stall(out_stall),
		.percent(percent), .present(present), .charging(charging), .ntc_fault(ntc_fault)
	);

	bvp_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.battery_mv(battery_mv), .charge_status(charge_status), .ntc_status(ntc_status),
		.out_valid(out_valid), .out_stall(out_stall),
		.percent(percent), .present(present), .charging(charging), .ntc_fault(ntc_fault),
		.errors(errors), .pending(pending), .results(results)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(mv_t v, logic [1:0] cs, logic [2:0] ntc);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		battery_mv    <= v;
		charge_status <= cs;
		ntc_status    <= ntc;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// hold off the sender until every expected result is back
	task automatic drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, mv_t data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic set_window(int lo, int hi);
		drain();
		write_reg(REG_PRESENT_MIN, mv_t'(lo));
		write_reg(REG_PRESENT_MAX, mv_t'(hi));
		cfg_wr_en <= 1'b0;
		cur_lo = lo;
		cur_hi = hi;
	endtask

	function automatic mv_t pick_mv();
		int v;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: v = $urandom_range(4250, 3350);
			6: begin
				v = ($urandom_range(1) ? cur_lo : cur_hi) + $urandom_range(6) - 3;
				if (v < 0)
					v = 0;
				if (v > 8191)
					v = 8191;
			end
			default: v = $urandom_range(8191);
		endcase
		return mv_t'(v);
	endfunction

	initial begin : stimulus
		int dir_mv [26] = '{
			0, 8191, 2499, 2500, 4600, 4601, 3399, 3400, 3401, 3425,
			3449, 3455, 3475, 3925, 3950, 3999, 4000, 4001, 4199, 4200,
			4201, 3875, 4095, 4096, 1234, 6000
		};
		int win_lo [NUM_WIN] = '{2500, 0, 4000, 3600, 8191, 0, 3300, 2500};
		int win_hi [NUM_WIN] = '{4600, 8191, 3000, 3600, 8191, 0, 4300, 4600};
		int idle_tab [4]  = '{0, 68, 0, 38};
		int stall_tab [4] = '{0, 0, 68, 38};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset window first, then the directed list
		for (int i = 0; i < 26; i++)
			send_item(mv_t'(dir_mv[i]), 2'(i % 4), 3'(i % 8));
		drain();

		for (int w = 0; w < NUM_WIN; w++) begin
			if (w != 0)
				set_window(win_lo[w], win_hi[w]);
			for (int p = 0; p < 4; p++) begin
				idle_pct = idle_tab[(p + w) % 4];
				stall_pct = stall_tab[(p + w) % 4];
				for (int n = 0; n < PHASE_LEN / 4; n++) begin
					if ($urandom_range(149) == 0)
						drain();
					send_item(pick_mv(), 2'($urandom_range(3)), 3'($urandom_range(7)));
				end
			end
		end

		idle_pct = 0;
		stall_pct = 0;
		drain();
		repeat (8) @(posedge clk);

		$display("Checked %0d results from %0d transfers over %0d presence windows,",
			results, sent, NUM_WIN);
		$display("each with free-running, sender-gap, receiver-stall and mixed flow control.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
